@@ rtl/core/mts_pkg.sv @@
// Shared types and constants for the MIDI track note scheduler.
// Used by mts_track_mem and midi_track_note_scheduler; no dependencies.
package mts_pkg;

   // Channel and result counts
   localparam int CHANNELS    = 16;
   localparam int MAX_RESULTS = 16;

   // Field widths
   localparam int CSR_DATA_W = 20;
   localparam int POS_W      = 24;
   localparam int PROD_W     = 28;

   // Configuration register indexes
   localparam logic [1:0] CSR_SAMPLES_PER_TICK = 2'd0;
   localparam logic [1:0] CSR_TRACK_COUNT      = 2'd1;
   localparam logic [1:0] CSR_DEVICE_OPEN      = 2'd2;

   // Register reset values
   localparam logic [19:0] SAMPLES_PER_TICK_RESET = 20'd5250;
   localparam logic [4:0]  TRACK_COUNT_RESET      = 5'd1;

   // MIDI status bytes (channel in the low nibble)
   localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
   localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
   localparam logic [7:0] MIDI_PROGRAM  = 8'hC0;

   // Special field codes
   localparam logic [7:0]  NOTE_NONE        = 8'd0;
   localparam logic [7:0]  NOTE_OFF         = 8'hFF;
   localparam logic [7:0]  VELOCITY_KEEP    = 8'hFF;
   localparam logic [7:0]  VELOCITY_DEFAULT = 8'h7F;
   localparam logic [7:0]  DELAY_KEEP       = 8'd0;
   localparam logic [7:0]  CHANNEL_KEEP     = 8'hFF;
   localparam logic [15:0] PROGRAM_NONE     = 16'hFFFF;
   localparam logic [23:0] POS_MAX          = 24'hFFFFFF;

   // Input item kinds
   typedef enum logic [1:0] {
      MODE_ROW   = 2'd0,
      MODE_TICK  = 2'd1,
      MODE_BLOCK = 2'd2,
      MODE_STOP  = 2'd3
   } mode_type;

   // Sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ROW,
      SEQ_PROG,
      SEQ_WALK,
      SEQ_DRAIN,
      SEQ_FLUSH
   } seq_state_type;

   // One track's stored state
   typedef struct packed {
      logic [7:0]  pending_note;
      logic [7:0]  sounding_note;
      logic        sounding_valid;
      logic [7:0]  velocity;
      logic [19:0] trigger_delay;
      logic [3:0]  channel;
   } track_entry_type;

   localparam track_entry_type TRACK_ENTRY_RESET = '{
      pending_note:   8'd0,
      sounding_note:  8'd0,
      sounding_valid: 1'b0,
      velocity:       8'h7F,
      trigger_delay:  20'd0,
      channel:        4'd0
   };

endpackage

@@ rtl/core/mts_track_mem.sv @@
// Per-track state memory: one read and one write port, registered read data.
// Per-entry valid flops make unwritten entries read as the reset entry.
// Depends on mts_pkg.
module mts_track_mem #(
   parameter int TRACKS = 16,
   localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [TW-1:0]            rd_addr,
   output mts_pkg::track_entry_type rd_data,
   input  logic                     wr_en,
   input  logic [TW-1:0]            wr_addr,
   input  mts_pkg::track_entry_type wr_data
);
   import mts_pkg::*;

   track_entry_type mem [TRACKS];
   logic [TRACKS-1:0] entry_valid_ff;
   track_entry_type rd_raw_ff;
   logic rd_valid_ff;

   // Storage array, read-first
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_raw_ff <= mem[rd_addr];
   end

   // Entry valid bits, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         rd_valid_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= entry_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_raw_ff : TRACK_ENTRY_RESET;

   // Assertions
   a_valid_after_write: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> entry_valid_ff[$past(wr_addr)])
      else $error("entry valid bit not set after write");

   a_valid_never_drops: assert property (@(posedge clock) disable iff (reset)
      $countones(entry_valid_ff) >= $countones($past(entry_valid_ff)) || $past(reset))
      else $error("entry valid bit dropped outside reset");

   a_read_reset_entry: assert property (@(posedge clock) disable iff (reset)
      !entry_valid_ff[rd_addr] && !(wr_en && wr_addr == rd_addr)
      |=> rd_data == TRACK_ENTRY_RESET)
      else $error("unwritten entry did not read as reset entry");

endmodule

@@ rtl/core/midi_track_note_scheduler.sv @@
// Top level of the MIDI track note scheduler: command port, sequencer,
// track state memory and message output. Depends on mts_pkg, mts_track_mem.
// Track row: busy in the row state (memory read in the accept cycle, then delay
// conversion and write back). Tick start: busy while a program change goes out
// on each channel, else not busy; results registered. Sample block / stop: busy
// walking min(track_count,16) tracks, then drain and flush; one track memory
// entry read and written per cycle; closed device or zero tracks: not busy.
// Results cannot be stalled. Synchronous reset clears control and track state.
module midi_track_note_scheduler #(
   parameter int TRACKS = 16,
   localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   // command port
   input  logic                            start,
   output logic                            busy,
   input  logic [1:0]                      req_mode,
   input  logic [3:0]                      req_track,
   input  logic [7:0]                      req_note,
   input  logic [7:0]                      req_velocity,
   input  logic [7:0]                      req_delay,
   input  logic [7:0]                      req_channel,
   input  logic [15:0]                     req_program_req,
   input  logic [11:0]                     req_sample_count,
   // result port
   output logic                            rsp_valid,
   output logic [7:0]                      rsp_status_byte,
   output logic [7:0]                      rsp_data_one,
   output logic [7:0]                      rsp_data_two,
   output logic                            rsp_last,
   // configuration port
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [mts_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mts_pkg::*;

   localparam int WALK_MAX = (TRACKS < MAX_RESULTS) ? TRACKS : MAX_RESULTS;

   // Delay conversion: floor(x/255) by base-256 long division
   function automatic logic [19:0] div255(input logic [PROD_W-1:0] x);
      logic [31:0] xe;
      logic [31:0] q;
      logic [7:0]  r;
      logic [7:0]  dig;
      logic [8:0]  s;
      xe = {4'd0, x};
      q  = '0;
      r  = '0;
      for (int k = 3; k >= 0; k--) begin
         dig = xe[k*8 +: 8];
         s   = {1'b0, r} + {1'b0, dig};
         if (s >= 9'd255) begin
            q[k*8 +: 8] = r + 8'd1;
            r           = 8'(s - 9'd255);
         end else begin
            q[k*8 +: 8] = r;
            r           = s[7:0];
         end
      end
      return q[19:0];
   endfunction

   // Configuration registers
   logic [19:0] spt_ff;
   logic [4:0]  trk_cnt_ff;
   logic        dev_open_ff;

   // Sequencer and item registers
   seq_state_type state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          proc_vld_ff, proc_vld_in;
   logic [TW-1:0] addr_ff, addr_in;
   logic [7:0]    note_ff, note_in;
   logic [7:0]    vel_ff, vel_in;
   logic [7:0]    dly_ff, dly_in;
   logic [7:0]    chan_ff, chan_in;
   logic [7:0]    prog_ff, prog_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  lo_ff, lo_in;
   logic [POS_W:0]    hi_ff, hi_in;

   // Held message (one behind, so the last one can be marked)
   logic       hold_vld_ff, hold_vld_in;
   logic [7:0] hold_st_ff, hold_st_in;
   logic [7:0] hold_d1_ff, hold_d1_in;
   logic [7:0] hold_d2_ff, hold_d2_in;

   // Output registers
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_st_ff, rsp_st_in;
   logic [7:0] rsp_d1_ff, rsp_d1_in;
   logic [7:0] rsp_d2_ff, rsp_d2_in;
   logic       rsp_last_ff, rsp_last_in;

   // Memory interface
   logic [TW-1:0]   mem_rd_addr;
   logic            mem_wr_en;
   track_entry_type mem_wr_data;
   track_entry_type rd_ent;

   // Datapath signals
   logic            accept;
   logic [4:0]      walk_lim;
   logic [POS_W:0]  pos_sum;
   track_entry_type row_upd;
   track_entry_type proc_upd;
   logic            in_window;
   logic [7:0]      key_num;
   logic            msg_vld;
   logic [7:0]      msg_st;
   logic [7:0]      msg_d1;
   logic [7:0]      msg_d2;

   mts_track_mem #(
      .TRACKS (TRACKS)
   ) u_track_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_ent),
      .wr_en   (mem_wr_en),
      .wr_addr (addr_ff),
      .wr_data (mem_wr_data)
   );

   assign busy      = (state_ff != SEQ_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign walk_lim = (trk_cnt_ff > 5'(WALK_MAX)) ? 5'(WALK_MAX) : trk_cnt_ff;
   assign pos_sum  = {1'b0, pos_ff} + 25'(req_sample_count);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         spt_ff      <= SAMPLES_PER_TICK_RESET;
         trk_cnt_ff  <= TRACK_COUNT_RESET;
         dev_open_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SAMPLES_PER_TICK: spt_ff      <= csr_data[19:0];
            CSR_TRACK_COUNT:      trk_cnt_ff  <= csr_data[4:0];
            CSR_DEVICE_OPEN:      dev_open_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // Track row update with delay conversion
   always_comb begin
      row_upd = rd_ent;
      if (note_ff != NOTE_NONE) begin
         row_upd.pending_note  = note_ff;
         row_upd.trigger_delay = '0;
         row_upd.velocity      = VELOCITY_DEFAULT;
      end
      if (vel_ff != VELOCITY_KEEP) begin
         row_upd.velocity = vel_ff;
      end
      if (dly_ff != DELAY_KEEP) begin
         row_upd.trigger_delay = div255(prod_ff);
      end
      if (chan_ff != CHANNEL_KEEP) begin
         row_upd.channel = chan_ff[3:0];
      end
   end

   // Walk stage: trigger check, note-on/off, stop
   always_comb begin
      proc_upd  = rd_ent;
      msg_vld   = 1'b0;
      msg_st    = '0;
      msg_d1    = '0;
      msg_d2    = '0;
      in_window = ({4'd0, rd_ent.trigger_delay} >= lo_ff)
               && ({5'd0, rd_ent.trigger_delay} <= hi_ff);
      key_num   = ({4'd0, rd_ent.pending_note[7:4]} << 3)
                + ({4'd0, rd_ent.pending_note[7:4]} << 2)
                + {4'd0, rd_ent.pending_note[3:0]} - 8'd1;
      if (mode_ff == MODE_BLOCK) begin
         if (rd_ent.pending_note != NOTE_NONE && in_window) begin
            if (rd_ent.pending_note != NOTE_OFF) begin
               msg_vld                 = 1'b1;
               msg_st                  = MIDI_NOTE_ON | {4'd0, rd_ent.channel};
               msg_d1                  = key_num;
               msg_d2                  = rd_ent.velocity;
               proc_upd.sounding_note  = key_num;
               proc_upd.sounding_valid = 1'b1;
            end else if (rd_ent.sounding_valid) begin
               msg_vld                 = 1'b1;
               msg_st                  = MIDI_NOTE_OFF | {4'd0, rd_ent.channel};
               msg_d1                  = rd_ent.sounding_note;
               proc_upd.sounding_note  = '0;
               proc_upd.sounding_valid = 1'b0;
            end
            proc_upd.pending_note = NOTE_NONE;
         end
      end else begin
         if (rd_ent.sounding_valid) begin
            msg_vld                 = 1'b1;
            msg_st                  = MIDI_NOTE_OFF | {4'd0, rd_ent.channel};
            msg_d1                  = rd_ent.sounding_note;
            proc_upd.pending_note   = NOTE_NONE;
            proc_upd.sounding_note  = '0;
            proc_upd.sounding_valid = 1'b0;
         end
      end
   end

   // Sequencer: next state, memory control, message output
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      cnt_in       = cnt_ff;
      proc_vld_in  = 1'b0;
      addr_in      = addr_ff;
      note_in      = note_ff;
      vel_in       = vel_ff;
      dly_in       = dly_ff;
      chan_in      = chan_ff;
      prog_in      = prog_ff;
      prod_in      = prod_ff;
      pos_in       = pos_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      hold_vld_in  = hold_vld_ff;
      hold_st_in   = hold_st_ff;
      hold_d1_in   = hold_d1_ff;
      hold_d2_in   = hold_d2_ff;
      rsp_valid_in = 1'b0;
      rsp_st_in    = hold_st_ff;
      rsp_d1_in    = hold_d1_ff;
      rsp_d2_in    = hold_d2_ff;
      rsp_last_in  = 1'b0;
      mem_rd_addr  = TW'(cnt_ff);
      mem_wr_en    = 1'b0;
      mem_wr_data  = proc_upd;

      // retire the walk stage: write back, push message through the hold
      if (proc_vld_ff) begin
         mem_wr_en = 1'b1;
         if (msg_vld) begin
            rsp_valid_in = hold_vld_ff;
            hold_vld_in  = 1'b1;
            hold_st_in   = msg_st;
            hold_d1_in   = msg_d1;
            hold_d2_in   = msg_d2;
         end
      end

      unique case (state_ff)
         SEQ_IDLE: begin
            if (accept) begin
               mode_in = mode_type'(req_mode);
               note_in = req_note;
               vel_in  = req_velocity;
               dly_in  = req_delay;
               chan_in = req_channel;
               prog_in = req_program_req[7:0];
               prod_in = PROD_W'(spt_ff) * PROD_W'(req_delay);
               cnt_in  = '0;
               unique case (mode_type'(req_mode))
                  MODE_ROW: begin
                     if (32'(req_track) < TRACKS) begin
                        mem_rd_addr = TW'(req_track);
                        addr_in     = TW'(req_track);
                        state_in    = SEQ_ROW;
                     end
                  end
                  MODE_TICK: begin
                     pos_in = '0;
                     if (dev_open_ff && req_program_req != PROGRAM_NONE) begin
                        state_in = SEQ_PROG;
                     end
                  end
                  MODE_BLOCK: begin
                     lo_in  = pos_ff;
                     hi_in  = pos_sum;
                     pos_in = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];
                     if (dev_open_ff && walk_lim != 5'd0) begin
                        state_in = SEQ_WALK;
                     end
                  end
                  MODE_STOP: begin
                     if (dev_open_ff && walk_lim != 5'd0) begin
                        state_in = SEQ_WALK;
                     end
                  end
                  default: ;
               endcase
            end
         end
         SEQ_ROW: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = row_upd;
            state_in    = SEQ_IDLE;
         end
         SEQ_PROG: begin
            rsp_valid_in = 1'b1;
            rsp_st_in    = MIDI_PROGRAM | {4'd0, cnt_ff[3:0]};
            rsp_d1_in    = prog_ff;
            rsp_d2_in    = '0;
            rsp_last_in  = (cnt_ff == 5'(CHANNELS - 1));
            cnt_in       = cnt_ff + 5'd1;
            if (cnt_ff == 5'(CHANNELS - 1)) begin
               state_in = SEQ_IDLE;
            end
         end
         SEQ_WALK: begin
            mem_rd_addr = TW'(cnt_ff);
            addr_in     = TW'(cnt_ff);
            proc_vld_in = 1'b1;
            cnt_in      = cnt_ff + 5'd1;
            if (cnt_ff == walk_lim - 5'd1) begin
               state_in = SEQ_DRAIN;
            end
         end
         SEQ_DRAIN: begin
            state_in = SEQ_FLUSH;
         end
         SEQ_FLUSH: begin
            rsp_valid_in = hold_vld_ff;
            rsp_last_in  = 1'b1;
            hold_vld_in  = 1'b0;
            state_in     = SEQ_IDLE;
         end
         default: state_in = SEQ_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         mode_ff      <= MODE_ROW;
         cnt_ff       <= '0;
         proc_vld_ff  <= 1'b0;
         pos_ff       <= '0;
         hold_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         cnt_ff       <= cnt_in;
         proc_vld_ff  <= proc_vld_in;
         pos_ff       <= pos_in;
         hold_vld_ff  <= hold_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff     <= addr_in;
      note_ff     <= note_in;
      vel_ff      <= vel_in;
      dly_ff      <= dly_in;
      chan_ff     <= chan_in;
      prog_ff     <= prog_in;
      prod_ff     <= prod_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      hold_st_ff  <= hold_st_in;
      hold_d1_ff  <= hold_d1_in;
      hold_d2_ff  <= hold_d2_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_d1_ff   <= rsp_d1_in;
      rsp_d2_ff   <= rsp_d2_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status_byte = rsp_st_ff;
   assign rsp_data_one    = rsp_d1_ff;
   assign rsp_data_two    = rsp_d2_ff;
   assign rsp_last        = rsp_last_ff;

   // Assertions
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !rsp_valid)
      else $error("message follows the last one of a transaction");

   a_hold_empty_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_IDLE |-> !hold_vld_ff)
      else $error("held message left behind at idle");

   a_walk_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == SEQ_WALK |-> cnt_ff < walk_lim)
      else $error("walk index beyond track limit");

   a_write_while_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> state_ff != SEQ_IDLE && state_ff != SEQ_PROG)
      else $error("track memory written outside row or walk");

endmodule

@@ bench/tb_midi_track_note_scheduler.sv @@
// Testbench for midi_track_note_scheduler: directed and random command traffic,
// checked message by message against an in-bench prediction of the scheduler.
// Depends on mts_pkg and midi_track_note_scheduler.
module tb_midi_track_note_scheduler;
   import mts_pkg::*;

   localparam int HALF_PERIOD    = 2;
   localparam int TIMEOUT_UNITS  = 2_000_000;
   localparam int RANDOM_ITEMS   = 400;
   localparam int MAX_GAP        = 13;
   localparam int DRAIN_LIMIT    = 4000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int ERROR_PRINTS   = 40;
   localparam int TB_TRACKS      = 16;
   localparam int DELAY_DIVISOR  = 255;
   localparam logic [11:0] COUNT_MAX = 12'hFFF;
   localparam logic [19:0] SPT_MAX   = 20'hFFFFF;

   // One command transaction
   typedef struct {
      mode_type    mode;
      logic [3:0]  track;
      logic [7:0]  note;
      logic [7:0]  velocity;
      logic [7:0]  delay;
      logic [7:0]  channel;
      logic [15:0] program_req;
      logic [11:0] sample_count;
   } sched_cmd_type;

   // One MIDI message on the result port
   typedef struct packed {
      logic [7:0] status;
      logic [7:0] data_one;
      logic [7:0] data_two;
      logic       last;
   } midi_msg_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [3:0]  req_track;
   logic [7:0]  req_note;
   logic [7:0]  req_velocity;
   logic [7:0]  req_delay;
   logic [7:0]  req_channel;
   logic [15:0] req_program_req;
   logic [11:0] req_sample_count;
   logic        rsp_valid;
   logic [7:0]  rsp_status_byte;
   logic [7:0]  rsp_data_one;
   logic [7:0]  rsp_data_two;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic [1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Predicted scheduler state and configuration
   logic [7:0]  pend_note [TB_TRACKS];
   logic [7:0]  sound_note [TB_TRACKS];
   bit          sound_on [TB_TRACKS];
   logic [7:0]  trk_vel [TB_TRACKS];
   logic [19:0] trk_delay [TB_TRACKS];
   logic [3:0]  trk_chan [TB_TRACKS];
   logic [23:0] sample_pos;
   logic [19:0] cfg_spt;
   logic [4:0]  cfg_tracks;
   bit          cfg_open;

   midi_msg_type expected_msgs[$];
   int unsigned error_count;
   int unsigned items_sent;
   int unsigned msgs_seen;
   int unsigned settings_count;
   bit          back_to_back;

   midi_track_note_scheduler u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_track        (req_track),
      .req_note         (req_note),
      .req_velocity     (req_velocity),
      .req_delay        (req_delay),
      .req_channel      (req_channel),
      .req_program_req  (req_program_req),
      .req_sample_count (req_sample_count),
      .rsp_valid        (rsp_valid),
      .rsp_status_byte  (rsp_status_byte),
      .rsp_data_one     (rsp_data_one),
      .rsp_data_two     (rsp_data_two),
      .rsp_last         (rsp_last),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Error reporting; output is capped, counting is not
   task automatic report_error(input string what);
      error_count++;
      if (error_count <= ERROR_PRINTS) $display("[%0t] error: %s", $time, what);
   endtask

   // One message, not yet marked last
   function automatic midi_msg_type make_msg(input logic [7:0] st, input logic [7:0] d1,
                                             input logic [7:0] d2);
      midi_msg_type m;
      m = '{st, d1, d2, 1'b0};
      return m;
   endfunction

   // Work out the messages one accepted command produces
   task automatic predict_item(input sched_cmd_type c);
      midi_msg_type msgs[$];
      int unsigned walk;
      logic [27:0] product;
      logic [24:0] reach;
      logic [7:0]  key;
      walk = (cfg_tracks > TB_TRACKS) ? TB_TRACKS : cfg_tracks;
      reach = sample_pos + c.sample_count;
      case (c.mode)
         MODE_ROW: begin
            // a new note resets velocity and delay before the fields apply
            if (c.note != NOTE_NONE) begin
               pend_note[c.track] = c.note;
               trk_delay[c.track] = '0;
               trk_vel[c.track] = VELOCITY_DEFAULT;
            end
            if (c.velocity != VELOCITY_KEEP) trk_vel[c.track] = c.velocity;
            if (c.delay != DELAY_KEEP) begin
               product = cfg_spt * c.delay;
               trk_delay[c.track] = 20'(product / DELAY_DIVISOR);
            end
            if (c.channel != CHANNEL_KEEP) trk_chan[c.track] = c.channel[3:0];
         end
         MODE_TICK: begin
            sample_pos = '0;
            if (cfg_open && c.program_req != PROGRAM_NONE)
               for (int ch = 0; ch < CHANNELS; ch++)
                  msgs.insert(msgs.size(),
                              make_msg(MIDI_PROGRAM | 8'(ch), c.program_req[7:0], 8'd0));
         end
         MODE_BLOCK: begin
            // tracks whose delay falls inside this block fire in order
            for (int t = 0; t < walk; t++) begin
               if (cfg_open && pend_note[t] != NOTE_NONE &&
                   sample_pos <= trk_delay[t] && reach >= trk_delay[t]) begin
                  if (pend_note[t] != NOTE_OFF) begin
                     key = 8'(12 * pend_note[t][7:4] + pend_note[t][3:0] - 1);
                     msgs.insert(msgs.size(),
                                 make_msg(MIDI_NOTE_ON | {4'd0, trk_chan[t]}, key, trk_vel[t]));
                     sound_note[t] = key;
                     sound_on[t] = 1'b1;
                  end else if (sound_on[t]) begin
                     msgs.insert(msgs.size(),
                                 make_msg(MIDI_NOTE_OFF | {4'd0, trk_chan[t]},
                                          sound_note[t], 8'd0));
                     sound_note[t] = '0;
                     sound_on[t] = 1'b0;
                  end
                  pend_note[t] = NOTE_NONE;
               end
            end
            sample_pos = (reach > POS_MAX) ? POS_MAX : reach[23:0];
         end
         MODE_STOP: begin
            if (cfg_open)
               for (int t = 0; t < walk; t++)
                  if (sound_on[t]) begin
                     msgs.insert(msgs.size(),
                                 make_msg(MIDI_NOTE_OFF | {4'd0, trk_chan[t]},
                                          sound_note[t], 8'd0));
                     pend_note[t] = NOTE_NONE;
                     sound_note[t] = '0;
                     sound_on[t] = 1'b0;
                  end
         end
      endcase
      if (msgs.size() > 0) msgs[msgs.size() - 1].last = 1'b1;
      foreach (msgs[i]) expected_msgs.insert(expected_msgs.size(), msgs[i]);
   endtask

   // Send one command transaction; start is left high for a following one
   task automatic send_item(input sched_cmd_type c);
      int unsigned gap;
      gap = back_to_back ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode         <= c.mode;
      req_track        <= c.track;
      req_note         <= c.note;
      req_velocity     <= c.velocity;
      req_delay        <= c.delay;
      req_channel      <= c.channel;
      req_program_req  <= c.program_req;
      req_sample_count <= c.sample_count;
      start            <= 1'b1;
      do @(posedge clock); while (busy);
      predict_item(c);
      items_sent++;
   endtask

   function automatic sched_cmd_type random_cmd();
      sched_cmd_type c;
      c.mode         = mode_type'($urandom_range(0, 3));
      c.track        = 4'($urandom);
      c.note         = 8'($urandom);
      c.velocity     = 8'($urandom);
      c.delay        = 8'($urandom);
      c.channel      = 8'($urandom);
      c.program_req  = 16'($urandom);
      c.sample_count = 12'($urandom);
      return c;
   endfunction

   // Command wrappers; fields a command does not use carry random values
   task automatic send_row(input logic [3:0] track, input logic [7:0] note,
                           input logic [7:0] vel, input logic [7:0] dly,
                           input logic [7:0] chan);
      sched_cmd_type c;
      c = random_cmd();
      c.mode = MODE_ROW;
      c.track = track;
      c.note = note;
      c.velocity = vel;
      c.delay = dly;
      c.channel = chan;
      send_item(c);
   endtask

   task automatic send_tick(input logic [15:0] prog);
      sched_cmd_type c;
      c = random_cmd();
      c.mode = MODE_TICK;
      c.program_req = prog;
      send_item(c);
   endtask

   task automatic send_block(input logic [11:0] count);
      sched_cmd_type c;
      c = random_cmd();
      c.mode = MODE_BLOCK;
      c.sample_count = count;
      send_item(c);
   endtask

   task automatic send_stop();
      sched_cmd_type c;
      c = random_cmd();
      c.mode = MODE_STOP;
      send_item(c);
   endtask

   // Hold off commands until every expected message is in and the block is idle
   task automatic wait_quiet();
      int unsigned waited;
      start <= 1'b0;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while ((expected_msgs.size() > 0 || busy) && waited < DRAIN_LIMIT);
      if (expected_msgs.size() > 0) begin
         report_error($sformatf("%0d expected messages never arrived", expected_msgs.size()));
         expected_msgs.delete();
      end
      if (busy) report_error("block still busy after drain");
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Configuration write transactions; valid stays high across the three
   task automatic csr_put(input logic [1:0] index, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(input logic [19:0] spt, input logic [4:0] tracks,
                               input bit open_dev);
      csr_put(CSR_SAMPLES_PER_TICK, spt);
      csr_put(CSR_TRACK_COUNT, {15'($urandom), tracks});
      csr_put(CSR_DEVICE_OPEN, {19'($urandom), open_dev});
      csr_valid <= 1'b0;
      cfg_spt = spt;
      cfg_tracks = tracks;
      cfg_open = open_dev;
      settings_count++;
   endtask

   // Reset settings, device closed: nothing may come out
   task automatic test_closed_device();
      send_row(4'd0, 8'h45, VELOCITY_KEEP, DELAY_KEEP, CHANNEL_KEEP);
      send_tick(16'h0012);
      send_block(COUNT_MAX);
      send_stop();
      wait_quiet();
   endtask

   // Program changes on all channels, and the no-program case
   task automatic test_program_change();
      write_config(20'd255, 5'd16, 1'b1);
      send_tick(16'hFF80);
      send_tick(PROGRAM_NONE);
      send_tick(16'h0000);
      wait_quiet();
   endtask

   // Note-on, note-off, replacement, off with nothing sounding, stop
   task automatic test_note_events();
      send_row(4'd0, 8'h01, 8'd200, DELAY_KEEP, 8'd9);
      send_row(4'd15, 8'hFC, 8'd0, 8'd255, 8'd15);
      send_row(4'd3, 8'h3A, VELOCITY_KEEP, 8'd128, 8'd254);
      send_row(4'd15, NOTE_NONE, 8'd10, DELAY_KEEP, CHANNEL_KEEP);
      send_tick(PROGRAM_NONE);
      send_block(12'd100);
      send_block(COUNT_MAX);
      send_row(4'd3, NOTE_OFF, VELOCITY_KEEP, 8'd1, CHANNEL_KEEP);
      send_row(4'd0, 8'h22, VELOCITY_KEEP, DELAY_KEEP, CHANNEL_KEEP);
      send_row(4'd5, NOTE_OFF, VELOCITY_KEEP, DELAY_KEEP, CHANNEL_KEEP);
      send_tick(PROGRAM_NONE);
      send_block(12'd0);
      send_block(12'd1);
      send_stop();
      send_stop();
      wait_quiet();
   endtask

   // Zero and oversized track counts, largest tick length
   task automatic test_track_limits();
      write_config(SPT_MAX, 5'd0, 1'b1);
      send_row(4'd0, 8'h11, VELOCITY_KEEP, 8'd1, 8'd2);
      send_tick(PROGRAM_NONE);
      send_block(COUNT_MAX);
      wait_quiet();
      write_config(SPT_MAX, 5'd31, 1'b1);
      send_tick(PROGRAM_NONE);
      send_block(COUNT_MAX);
      send_block(12'd100);
      send_stop();
      wait_quiet();
   endtask

   // Random phases: tick, rows, blocks and stops with random settings
   task automatic test_random_traffic();
      int unsigned first_item;
      int unsigned walk;
      int unsigned span;
      logic [19:0] spt;
      logic [4:0]  tracks;
      logic [3:0]  track;
      logic [7:0]  note;
      sched_cmd_type c;
      first_item = items_sent;
      while (items_sent - first_item < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: spt = 20'd1;
            1: spt = SPT_MAX;
            2: spt = SAMPLES_PER_TICK_RESET;
            3: spt = 20'($urandom_range(2, 4000));
            default: spt = 20'($urandom_range(1, SPT_MAX));
         endcase
         case ($urandom_range(0, 9))
            0: tracks = 5'd0;
            1: tracks = 5'd31;
            2: tracks = 5'd16;
            3: tracks = 5'd1;
            default: tracks = 5'($urandom_range(1, 16));
         endcase
         write_config(spt, tracks, $urandom_range(0, 7) != 0);
         back_to_back = ($urandom_range(0, 3) == 0);
         walk = (cfg_tracks > TB_TRACKS) ? TB_TRACKS : cfg_tracks;
         span = (cfg_spt < COUNT_MAX) ? cfg_spt : COUNT_MAX;
         repeat ($urandom_range(4, 8)) begin
            if ($urandom_range(0, 9) == 0) begin
               c = random_cmd();
               send_item(c);
            end else begin
               send_tick($urandom_range(0, 1) ? PROGRAM_NONE : 16'($urandom));
               repeat ($urandom_range(1, 4)) begin
                  track = (walk > 0 && $urandom_range(0, 9) != 0) ?
                          4'($urandom_range(0, walk - 1)) : 4'($urandom);
                  case ($urandom_range(0, 9))
                     0: note = NOTE_NONE;
                     1: note = NOTE_OFF;
                     2: note = 8'($urandom);
                     default: note = {4'($urandom), 4'($urandom_range(1, 12))};
                  endcase
                  send_row(track, note,
                           $urandom_range(0, 1) ? VELOCITY_KEEP : 8'($urandom),
                           $urandom_range(0, 1) ? DELAY_KEEP : 8'($urandom),
                           $urandom_range(0, 1) ? CHANNEL_KEEP : 8'($urandom));
               end
               repeat ($urandom_range(1, 5))
                  send_block($urandom_range(0, 1) ? 12'($urandom) :
                                                    12'($urandom_range(0, span)));
               if ($urandom_range(0, 4) == 0) send_stop();
            end
         end
         back_to_back = 1'b0;
         wait_quiet();
      end
   endtask

   // Result checking: every message against the oldest expectation
   always @(posedge clock) begin
      midi_msg_type want;
      if (!reset && rsp_valid) begin
         msgs_seen++;
         if (expected_msgs.size() == 0) begin
            report_error($sformatf("unexpected message %02h %02h %02h last=%0b",
                                   rsp_status_byte, rsp_data_one, rsp_data_two, rsp_last));
         end else begin
            want = expected_msgs.pop_front();
            if (rsp_status_byte !== want.status)
               report_error($sformatf("status %02h, expected %02h",
                                      rsp_status_byte, want.status));
            if (rsp_data_one !== want.data_one)
               report_error($sformatf("data_one %02h, expected %02h",
                                      rsp_data_one, want.data_one));
            if (rsp_data_two !== want.data_two)
               report_error($sformatf("data_two %02h, expected %02h",
                                      rsp_data_two, want.data_two));
            if (rsp_last !== want.last)
               report_error($sformatf("last %0b, expected %0b", rsp_last, want.last));
         end
      end
   end

   // Main sequence
   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_mode = MODE_ROW;
      req_track = '0;
      req_note = '0;
      req_velocity = '0;
      req_delay = '0;
      req_channel = '0;
      req_program_req = '0;
      req_sample_count = '0;
      csr_valid = 1'b0;
      csr_index = CSR_SAMPLES_PER_TICK;
      csr_data = '0;
      cfg_spt = SAMPLES_PER_TICK_RESET;
      cfg_tracks = TRACK_COUNT_RESET;
      cfg_open = 1'b0;
      sample_pos = '0;
      back_to_back = 1'b0;
      for (int t = 0; t < TB_TRACKS; t++) begin
         pend_note[t] = NOTE_NONE;
         sound_note[t] = '0;
         sound_on[t] = 1'b0;
         trk_vel[t] = VELOCITY_DEFAULT;
         trk_delay[t] = '0;
         trk_chan[t] = '0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_closed_device();
      test_program_change();
      test_note_events();
      test_track_limits();
      test_random_traffic();
      wait_quiet();
      $display("Run covered %0d commands and %0d MIDI messages over %0d register settings,",
               items_sent, msgs_seen, settings_count);
      $display("including closed device, program changes and track count limits.");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(TIMEOUT_UNITS);
      $display("FAIL");
      $finish;
   end

endmodule
